FILE: rtl/rbsf_pkg.sv
// Shared types, constants and bit positions for the start-field controller.
package rbsf_pkg;

    localparam int unsigned PhaseWidth = 3;
    localparam int unsigned DelayWidth = 16;
    localparam int unsigned LampCount  = 9;
    localparam int unsigned CfgIdxWidth = 2;
    localparam int unsigned InDataWidth  = 16;
    localparam int unsigned OutDataWidth = 16;

    localparam logic [DelayWidth-1:0] DelayResetTicks = 16'd500;

    typedef enum logic [PhaseWidth-1:0] {
        PH_FREE      = 3'd0,
        PH_OCCUPIED  = 3'd1,
        PH_PREDEPART = 3'd2,
        PH_DEPART    = 3'd3,
        PH_ENTRYSIG  = 3'd4,
        PH_COUPLING  = 3'd5,
        PH_FAULTWAIT = 3'd6
    } phase_t;

    typedef enum logic [CfgIdxWidth-1:0] {
        CFG_FIELD_BLOCK_MODE = 2'd0,
        CFG_KEY_BOX_DIRECT   = 2'd1,
        CFG_DEPART_DELAY     = 2'd2
    } cfg_idx_t;

    // Positions in the lamp register, matching the order of the result fields.
    localparam int unsigned L_DEPART   = 0;
    localparam int unsigned L_NOSTOP   = 1;
    localparam int unsigned L_KEYOK    = 2;
    localparam int unsigned L_EXITLOCK = 3;
    localparam int unsigned L_BLOCK    = 4;
    localparam int unsigned L_PREBLOCK = 5;
    localparam int unsigned L_REPEAT   = 6;
    localparam int unsigned L_GREEN    = 7;
    localparam int unsigned L_RELAY    = 8;

    typedef struct packed {
        logic ms_tick;
        logic link_fault;
        logic back_block_received;
        logic aux_allowed;
        logic aux_key_press;
        logic exit_contact;
        logic entry_contact;
        logic entry_signal_clear;
        logic exit_signal_clear;
    } step_in_t;

    typedef struct packed {
        logic                 start_indicator;
        logic                 send_preblock;
        logic [LampCount-1:0] lamps;
        phase_t               phase;
    } step_out_t;

endpackage

FILE: rtl/railway_block_start_field_fsm_core.sv
// Start-field controller of a line block: phase machine, key latch, delay timer, lamps.
// Each result is registered: it appears on m_tdata in the cycle after its input beat is accepted.
// Throughput: one beat per cycle while m_tready is high; the step logic sits between the
// state registers and a single output register, and s_tready stays high while it drains.
// Reset (rst_n low, asynchronous): free phase with entry actions due, key latch and
// delay count cleared, all lamps off, registers at their documented defaults.
module railway_block_start_field_fsm_core (
    input  logic        clk,
    input  logic        rst_n,
    // Input beat.
    input  logic        s_tvalid,
    output logic        s_tready,
    // [0] exit_signal_clear, [1] entry_signal_clear, [2] entry_contact,
    // [3] exit_contact, [4] aux_key_press, [5] aux_allowed,
    // [6] back_block_received, [7] link_fault, [8] ms_tick, [15:9] zero
    input  logic [rbsf_pkg::InDataWidth-1:0]  s_tdata,
    // Result beat.
    output logic        m_tvalid,
    input  logic        m_tready,
    // [2:0] phase, [3] depart_possible, [4] no_forced_stop, [5] key_removal_ok,
    // [6] exit_lock_lamp, [7] block_lamp, [8] preblock_lamp, [9] repeat_lock_lamp,
    // [10] green_led, [11] key_relay, [12] send_preblock, [13] start_indicator,
    // [15:14] zero
    output logic [rbsf_pkg::OutDataWidth-1:0] m_tdata,
    // Configuration writes.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [rbsf_pkg::CfgIdxWidth-1:0] cfg_index,
    input  logic [rbsf_pkg::DelayWidth-1:0]  cfg_data
);

    rbsf_pkg::phase_t                     phase_reg, phase_next;
    rbsf_pkg::phase_t                     phase_cur;
    logic                                 entering;
    logic                                 entry_pending_reg, entry_pending_next;
    logic                                 key_latch_reg, key_latch_next;
    logic [rbsf_pkg::DelayWidth-1:0]      delay_count_reg, delay_count_next;
    logic [rbsf_pkg::LampCount-1:0]       lamp_reg, lamp_next;
    logic                                 mode_reg;
    logic                                 box_direct_reg;
    logic [rbsf_pkg::DelayWidth-1:0]      delay_ticks_reg;
    logic                                 m_tvalid_reg;
    logic [rbsf_pkg::OutDataWidth-1:0]    m_tdata_reg;
    rbsf_pkg::step_in_t                   step_in;
    rbsf_pkg::step_out_t                  step_out;
    logic                                 send_next;
    logic                                 start_next;
    logic                                 s_accept;

    assign step_in   = s_tdata[$bits(rbsf_pkg::step_in_t)-1:0];
    assign s_tready  = !m_tvalid_reg || m_tready;
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    always_comb
    begin
        // An unused phase code is taken as free with its entry actions due in this step.
        phase_cur = phase_reg;
        entering  = entry_pending_reg;
        if (phase_reg > rbsf_pkg::PH_FAULTWAIT)
        begin
            phase_cur = rbsf_pkg::PH_FREE;
            entering  = 1'b1;
        end

        phase_next         = phase_cur;
        entry_pending_next = 1'b0;
        key_latch_next     = key_latch_reg | step_in.aux_key_press;
        delay_count_next   = delay_count_reg;
        lamp_next          = lamp_reg;
        send_next          = 1'b0;
        start_next         = 1'b0;

        case (phase_cur)
            rbsf_pkg::PH_FREE:
            begin
                if (entering)
                begin
                    key_latch_next = 1'b0;
                    lamp_next[rbsf_pkg::L_DEPART]   = 1'b1;
                    lamp_next[rbsf_pkg::L_NOSTOP]   = 1'b1;
                    lamp_next[rbsf_pkg::L_KEYOK]    = 1'b1;
                    lamp_next[rbsf_pkg::L_EXITLOCK] = 1'b0;
                    lamp_next[rbsf_pkg::L_BLOCK]    = 1'b0;
                    lamp_next[rbsf_pkg::L_PREBLOCK] = 1'b0;
                    lamp_next[rbsf_pkg::L_GREEN]    = 1'b0;
                    if (box_direct_reg)
                    begin
                        lamp_next[rbsf_pkg::L_RELAY] = 1'b1;
                    end
                end
                else if (step_in.exit_signal_clear)
                begin
                    phase_next         = rbsf_pkg::PH_PREDEPART;
                    entry_pending_next = 1'b1;
                end
                else if (step_in.aux_allowed && key_latch_next)
                begin
                    key_latch_next     = 1'b0;
                    phase_next         = rbsf_pkg::PH_OCCUPIED;
                    entry_pending_next = 1'b1;
                end
            end
            rbsf_pkg::PH_OCCUPIED:
            begin
                if (entering)
                begin
                    send_next = 1'b1;
                    lamp_next[rbsf_pkg::L_DEPART]   = 1'b0;
                    lamp_next[rbsf_pkg::L_NOSTOP]   = 1'b0;
                    lamp_next[rbsf_pkg::L_KEYOK]    = 1'b0;
                    lamp_next[rbsf_pkg::L_REPEAT]   = 1'b0;
                    lamp_next[rbsf_pkg::L_BLOCK]    = 1'b1;
                    lamp_next[rbsf_pkg::L_PREBLOCK] = 1'b1;
                    lamp_next[rbsf_pkg::L_GREEN]    = 1'b1;
                    key_latch_next = 1'b0;
                    if (box_direct_reg)
                    begin
                        lamp_next[rbsf_pkg::L_RELAY] = 1'b0;
                    end
                end
                else if (step_in.back_block_received)
                begin
                    start_next         = 1'b1;
                    phase_next         = rbsf_pkg::PH_FREE;
                    entry_pending_next = 1'b1;
                end
            end
            rbsf_pkg::PH_PREDEPART:
            begin
                if (entering)
                begin
                    delay_count_next = delay_ticks_reg;
                    lamp_next[rbsf_pkg::L_EXITLOCK] = 1'b1;
                    lamp_next[rbsf_pkg::L_REPEAT]   = 1'b1;
                    lamp_next[rbsf_pkg::L_KEYOK]    = 1'b0;
                    if (box_direct_reg)
                    begin
                        lamp_next[rbsf_pkg::L_RELAY] = 1'b0;
                    end
                end
                else if (step_in.ms_tick)
                begin
                    if (delay_count_reg == '0)
                    begin
                        lamp_next[rbsf_pkg::L_DEPART] = 1'b0;
                        phase_next         = rbsf_pkg::PH_DEPART;
                        entry_pending_next = 1'b1;
                    end
                    else
                    begin
                        delay_count_next = delay_count_reg - 1'b1;
                    end
                end
            end
            rbsf_pkg::PH_DEPART:
            begin
                if (entering)
                begin
                    key_latch_next = 1'b0;
                end
                else if (step_in.entry_signal_clear)
                begin
                    phase_next         = rbsf_pkg::PH_ENTRYSIG;
                    entry_pending_next = 1'b1;
                end
                else if (step_in.entry_contact || step_in.exit_contact)
                begin
                    phase_next         = rbsf_pkg::PH_COUPLING;
                    entry_pending_next = 1'b1;
                end
                else if (!step_in.exit_signal_clear && key_latch_next)
                begin
                    phase_next         = rbsf_pkg::PH_OCCUPIED;
                    entry_pending_next = 1'b1;
                end
            end
            rbsf_pkg::PH_ENTRYSIG:
            begin
                if (!entering && !step_in.entry_signal_clear)
                begin
                    phase_next         = rbsf_pkg::PH_DEPART;
                    entry_pending_next = 1'b1;
                end
            end
            rbsf_pkg::PH_COUPLING:
            begin
                if (entering)
                begin
                    lamp_next[rbsf_pkg::L_NOSTOP] = 1'b0;
                    key_latch_next = 1'b0;
                end
                else if (!step_in.exit_signal_clear)
                begin
                    if (step_in.link_fault)
                    begin
                        phase_next         = rbsf_pkg::PH_FAULTWAIT;
                        entry_pending_next = 1'b1;
                    end
                    else if (!mode_reg || key_latch_next)
                    begin
                        phase_next         = rbsf_pkg::PH_OCCUPIED;
                        entry_pending_next = 1'b1;
                    end
                end
                else
                begin
                    key_latch_next = 1'b0;
                end
            end
            rbsf_pkg::PH_FAULTWAIT:
            begin
                if (entering)
                begin
                    key_latch_next = 1'b0;
                end
                else if (!step_in.link_fault && key_latch_next)
                begin
                    phase_next         = rbsf_pkg::PH_OCCUPIED;
                    entry_pending_next = 1'b1;
                end
            end
            default:
            begin
                // Codes above faultwait have already been mapped to free.
            end
        endcase

        step_out.phase           = phase_next;
        step_out.lamps           = lamp_next;
        step_out.send_preblock   = send_next;
        step_out.start_indicator = start_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= rbsf_pkg::PH_FREE;
            entry_pending_reg <= 1'b1;
            key_latch_reg     <= 1'b0;
            delay_count_reg   <= '0;
            lamp_reg          <= '0;
            mode_reg          <= 1'b0;
            box_direct_reg    <= 1'b0;
            delay_ticks_reg   <= rbsf_pkg::DelayResetTicks;
            m_tvalid_reg      <= 1'b0;
            m_tdata_reg       <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    rbsf_pkg::CFG_FIELD_BLOCK_MODE: mode_reg        <= cfg_data[0];
                    rbsf_pkg::CFG_KEY_BOX_DIRECT:   box_direct_reg  <= cfg_data[0];
                    rbsf_pkg::CFG_DEPART_DELAY:     delay_ticks_reg <= cfg_data;
                    default:                        ;
                endcase
            end
            if (s_accept)
            begin
                phase_reg         <= phase_next;
                entry_pending_reg <= entry_pending_next;
                key_latch_reg     <= key_latch_next;
                delay_count_reg   <= delay_count_next;
                lamp_reg          <= lamp_next;
                m_tvalid_reg      <= 1'b1;
                m_tdata_reg       <= rbsf_pkg::OutDataWidth'(step_out);
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

endmodule
